// File: design/cdq_pkg.sv
// Shared types and codes for the circular deque.
package cdq_pkg;

    localparam int FIELD_WORD_BITS  = 32;
    localparam int FIELD_COUNT_BITS = 11;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                               cmd;
        logic signed [FIELD_WORD_BITS-1:0]  push_word;
    } in_t;

    typedef struct packed {
        status_t                            status;
        logic signed [FIELD_WORD_BITS-1:0]  popped_word;
        logic [FIELD_COUNT_BITS-1:0]        item_count;
        logic                               empty_flag;
        logic signed [FIELD_WORD_BITS-1:0]  front_word;
        logic signed [FIELD_WORD_BITS-1:0]  back_word;
    } out_t;

endpackage

// File: design/cdq_ram.sv
// Generic RAM: one write port, two registered read ports, read-first.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: design/circular_deque.sv
// Circular deque: ring store with front/back pointers and cached end words.
//
// Input channel s_valid/s_ready/s_data carries one operation per word:
// push front, push back, pop front or pop back, with the word to push.
// Result channel m_valid/m_ready/m_data returns one word per operation:
// status (done, full, empty), the popped word, and the item count, empty
// flag, front word and back word after the operation.
// An operation's result is registered on m_data in the cycle after the
// operation is accepted; one operation per cycle while m_ready is high.
// The front and back words live in registers; the second-from-front and
// second-from-back entries are prefetched every cycle through the two read
// ports of the ring RAM, with the last write forwarded past the RAM.
// While a result waits on a low m_ready, s_ready is low and the deque state holds;
// s_ready rises again in the cycle the result is taken.
// Reset (aresetn low at a clock edge) empties the deque and drops m_valid.
// The ring RAM itself is not cleared; read values are used only from written entries.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int PtrBits   = $clog2(DEPTH);
    localparam int CntBits   = $clog2(DEPTH + 1);
    localparam int StoreBits = (WORD_BITS < FIELD_WORD_BITS) ? WORD_BITS : FIELD_WORD_BITS;

    typedef logic [PtrBits-1:0]   ptr_t;
    typedef logic [CntBits-1:0]   cnt_t;
    typedef logic [StoreBits-1:0] word_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        return (p == '0) ? ptr_t'(DEPTH - 1) : ptr_t'(p - 1'b1);
    endfunction

    ptr_t  head_reg, head_next;
    ptr_t  tail_reg, tail_next;
    cnt_t  count_reg, count_next;
    word_t front_reg, front_next;
    word_t back_reg, back_next;
    logic  m_valid_reg;
    out_t  out_reg, out_next;

    // last write and prefetch addresses, for forwarding
    logic  wr_en_reg;
    ptr_t  wr_addr_reg;
    word_t wr_data_reg;
    ptr_t  rd_addr_a_reg, rd_addr_b_reg;

    logic  accept;
    logic  wr_en;
    ptr_t  wr_addr;
    word_t word_in;
    ptr_t  rd_addr_a, rd_addr_b;
    word_t rd_data_a, rd_data_b;
    word_t second_front, second_back;
    logic  is_full, none_held;
    status_t status;
    word_t popped;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign word_in   = s_data.push_word[StoreBits-1:0];
    assign is_full   = (count_reg == cnt_t'(DEPTH));
    assign none_held = (count_reg == '0);

    assign second_front = (wr_en_reg && wr_addr_reg == rd_addr_a_reg) ? wr_data_reg : rd_data_a;
    assign second_back  = (wr_en_reg && wr_addr_reg == rd_addr_b_reg) ? wr_data_reg : rd_data_b;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        front_next = front_reg;
        back_next  = back_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        status     = ST_DONE;
        popped     = '0;
        unique case (s_data.cmd)
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    head_next  = ptr_dec(head_reg);
                    wr_en      = accept;
                    wr_addr    = head_next;
                    front_next = word_in;
                    if (none_held) begin
                        back_next = word_in;
                    end
                    count_next = cnt_t'(count_reg + 1'b1);
                end
            end
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    tail_next = ptr_inc(tail_reg);
                    wr_en     = accept;
                    wr_addr   = tail_reg;
                    back_next = word_in;
                    if (none_held) begin
                        front_next = word_in;
                    end
                    count_next = cnt_t'(count_reg + 1'b1);
                end
            end
            CMD_POP_FRONT: begin
                if (none_held) begin
                    status = ST_EMPTY;
                end else begin
                    popped     = front_reg;
                    head_next  = ptr_inc(head_reg);
                    front_next = second_front;
                    count_next = cnt_t'(count_reg - 1'b1);
                end
            end
            CMD_POP_BACK: begin
                if (none_held) begin
                    status = ST_EMPTY;
                end else begin
                    popped     = back_reg;
                    tail_next  = ptr_dec(tail_reg);
                    back_next  = second_back;
                    count_next = cnt_t'(count_reg - 1'b1);
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    // prefetch the entries next to each end as they stand after this cycle
    always_comb begin
        if (accept) begin
            rd_addr_a = ptr_inc(head_next);
            rd_addr_b = ptr_dec(ptr_dec(tail_next));
        end else begin
            rd_addr_a = ptr_inc(head_reg);
            rd_addr_b = ptr_dec(ptr_dec(tail_reg));
        end
    end

    always_comb begin
        out_next.status      = status;
        out_next.popped_word = FIELD_WORD_BITS'(popped);
        out_next.item_count  = FIELD_COUNT_BITS'(count_next);
        out_next.empty_flag  = (count_next == '0);
        out_next.front_word  = (count_next == '0) ? '0 : FIELD_WORD_BITS'(front_next);
        out_next.back_word   = (count_next == '0) ? '0 : FIELD_WORD_BITS'(back_next);
    end

    cdq_ram #(
        .WIDTH(StoreBits),
        .DEPTH(DEPTH)
    ) u_ring (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (word_in),
        .rd_addr_a(rd_addr_a),
        .rd_data_a(rd_data_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_b(rd_data_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            wr_en_reg   <= 1'b0;
        end else begin
            wr_en_reg <= wr_en;
            if (accept) begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg   <= wr_addr;
        wr_data_reg   <= word_in;
        rd_addr_a_reg <= rd_addr_a;
        rd_addr_b_reg <= rd_addr_b;
        if (accept) begin
            front_reg <= front_next;
            back_reg  <= back_next;
            out_reg   <= out_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(DEPTH))
        else $error("item count above depth");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |->
            m_data.empty_flag && m_data.item_count == '0)
        else $error("empty refusal with items held");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_full &&
            (s_data.cmd == CMD_PUSH_FRONT || s_data.cmd == CMD_PUSH_BACK) |=>
            count_reg == cnt_t'($past(count_reg) + 1'b1))
        else $error("push did not add one item");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("word accepted over a stalled result");

endmodule
